### hw/rtl/gpe_pkg.sv
// ----------------------------------------------------------------------------
// Gray Prewitt edge threshold package
// Shared constants, register indexes and the item tag that passes from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W    = 8;
  localparam int POS_W    = 10;
  localparam int DIM_W    = 11;
  localparam int CUTOFF_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int KSUM_W   = 12;
  localparam int CSUM_W   = 10;

  // The mean of three channels is taken as (sum * 683) >> 11, exact for sums up to 765.
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_W     = 20;

  localparam int FIFO_DEPTH = 4;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 8'd95;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 11'd480;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } gpe_cfg_e;

  typedef struct packed {
    logic             full;
    logic             last;
    logic [POS_W-1:0] crow;
    logic [POS_W-1:0] ccol;
  } gpe_tag_t;

endpackage

### hw/rtl/gpe_front.sv
// ----------------------------------------------------------------------------
// Gray Prewitt front end
// Accepts RGB requests, converts them to gray, tracks the raster position and
// classifies each pixel before pushing it into the work queue.
// ----------------------------------------------------------------------------
module gpe_front import gpe_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH,
  parameter int MaxHeight = MAX_HEIGHT,
  localparam int CW = $clog2(MaxWidth),
  localparam int RW = $clog2(MaxHeight)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] red_in_i,
  input  logic [PIX_W-1:0] green_in_i,
  input  logic [PIX_W-1:0] blue_in_i,
  input  logic             frame_start_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  output logic             push_o,
  input  logic             push_ready_i,
  output logic [CW-1:0]    item_col_o,
  output logic [PIX_W-1:0] item_gray_o,
  output gpe_tag_t         item_tag_o
);

  localparam int WW  = CW + 1;
  localparam int HW  = RW + 1;
  localparam int SWW = (WW > DIM_W) ? WW : DIM_W;
  localparam int SHW = (HW > DIM_W) ? HW : DIM_W;

  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [WW-1:0]     w, c0, c;
  logic [HW-1:0]     h, r0, r;
  logic [SWW-1:0]    w_ext;
  logic [SHW-1:0]    h_ext;
  logic [CSUM_W-1:0] csum;
  logic [PROD_W-1:0] prod;
  logic              accept, full, last_col, last_row;

  assign accept     = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i;

  assign w_ext = SWW'(width_i);
  assign h_ext = SHW'(height_i);

  always_comb begin
    if (w_ext < SWW'(3)) begin
      w = WW'(3);
    end else if (w_ext > SWW'(MaxWidth)) begin
      w = WW'(MaxWidth);
    end else begin
      w = WW'(w_ext);
    end
    if (h_ext < SHW'(3)) begin
      h = HW'(3);
    end else if (h_ext > SHW'(MaxHeight)) begin
      h = HW'(MaxHeight);
    end else begin
      h = HW'(h_ext);
    end
  end

  always_comb begin
    c0 = frame_start_i ? '0 : WW'(col_q);
    r0 = frame_start_i ? '0 : HW'(row_q);
    c  = (c0 >= w) ? w - WW'(1) : c0;
    r  = (r0 >= h) ? h - HW'(1) : r0;
    full     = (c >= WW'(2)) && (r >= HW'(2));
    last_col = (c + WW'(1)) >= w;
    last_row = (r + HW'(1)) >= h;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : RW'(r + HW'(1));
    end else begin
      col_d = CW'(c + WW'(1));
      row_d = RW'(r);
    end
  end

  assign csum = CSUM_W'(red_in_i) + CSUM_W'(green_in_i) + CSUM_W'(blue_in_i);
  assign prod = PROD_W'(csum) * PROD_W'(DIV3_MUL);

  assign item_gray_o     = PIX_W'(prod >> DIV3_SHIFT);
  assign item_col_o      = CW'(c);
  assign item_tag_o.full = full;
  assign item_tag_o.last = last_col && last_row;
  assign item_tag_o.crow = full ? POS_W'(r - HW'(1)) : '0;
  assign item_tag_o.ccol = full ? POS_W'(c - WW'(1)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### hw/rtl/gpe_fifo.sv
// ----------------------------------------------------------------------------
// Gray Prewitt work queue
// A short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module gpe_fifo import gpe_pkg::*; #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int PW = $clog2(FIFO_DEPTH);

  logic [Width-1:0] mem_q [FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != (PW + 1)'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign cnt_d        = cnt_q + (PW + 1)'(do_push) - (PW + 1)'(do_pop);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/gpe_back.sv
// ----------------------------------------------------------------------------
// Gray Prewitt back end
// Reads and rotates the line store of two rows, keeps the 3x3 window, applies the
// Prewitt kernels, thresholds and holds the result in the output register.
// ----------------------------------------------------------------------------
module gpe_back import gpe_pkg::*; #(
  parameter int MaxWidth = MAX_WIDTH,
  localparam int CW = $clog2(MaxWidth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  output logic                head_ready_o,
  input  logic [CW-1:0]       head_col_i,
  input  logic [PIX_W-1:0]    head_gray_i,
  input  gpe_tag_t            head_tag_i,
  input  logic [CUTOFF_W-1:0] cutoff_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIX_W-1:0]    edge_value_o,
  output logic                window_full_o,
  output logic [POS_W-1:0]    center_row_o,
  output logic [POS_W-1:0]    center_col_o,
  output logic                frame_last_o
);

  localparam int LW = 2 * PIX_W;

  logic [LW-1:0]    line_mem [MaxWidth];
  logic [LW-1:0]    rd_q, fwd_q, cur;
  logic             hit_q;
  logic             s1_valid_q;
  logic [CW-1:0]    s1_col_q;
  logic [PIX_W-1:0] s1_gray_q;
  gpe_tag_t         s1_tag_q;
  logic [PIX_W-1:0] p0_top_q, p0_mid_q, p0_bot_q;
  logic [PIX_W-1:0] p1_top_q, p1_mid_q, p1_bot_q;
  logic [PIX_W-1:0] c_top, c_mid;
  logic signed [KSUM_W-1:0] gx, gy, gsum;
  logic             out_valid_q;
  logic [PIX_W-1:0] edge_q;
  gpe_tag_t         out_tag_q;
  logic             adv, pop, is_edge;

  assign adv          = s1_valid_q && (!out_valid_q || out_ready_i);
  assign head_ready_o = !s1_valid_q || adv;
  assign pop          = head_valid_i && head_ready_o;

  assign cur          = hit_q ? fwd_q : rd_q;
  assign c_top        = cur[LW-1:PIX_W];
  assign c_mid        = cur[PIX_W-1:0];

  // Each column of the store holds the upper and the lower row as one word.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_q  <= line_mem[head_col_i];
      fwd_q <= {c_mid, s1_gray_q};
    end
    if (adv) begin
      line_mem[s1_col_q] <= {c_mid, s1_gray_q};
    end
  end

  always_comb begin
    gx = $signed(KSUM_W'(c_top) + KSUM_W'(c_mid) + KSUM_W'(s1_gray_q))
       - $signed(KSUM_W'(p0_top_q) + KSUM_W'(p0_mid_q) + KSUM_W'(p0_bot_q));
    gy = $signed(KSUM_W'(p0_bot_q) + KSUM_W'(p1_bot_q) + KSUM_W'(s1_gray_q))
       - $signed(KSUM_W'(p0_top_q) + KSUM_W'(p1_top_q) + KSUM_W'(c_top));
    gsum    = gx + gy;
    is_edge = s1_tag_q.full && (gsum > $signed(KSUM_W'(cutoff_i)));
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_col_q  <= head_col_i;
      s1_gray_q <= head_gray_i;
      s1_tag_q  <= head_tag_i;
    end
    if (adv) begin
      edge_q    <= is_edge ? EDGE_ON : EDGE_OFF;
      out_tag_q <= s1_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      p0_top_q    <= '0;
      p0_mid_q    <= '0;
      p0_bot_q    <= '0;
      p1_top_q    <= '0;
      p1_mid_q    <= '0;
      p1_bot_q    <= '0;
    end else begin
      if (pop) begin
        s1_valid_q <= 1'b1;
        hit_q      <= adv && (head_col_i == s1_col_q);
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        p0_top_q    <= p1_top_q;
        p0_mid_q    <= p1_mid_q;
        p0_bot_q    <= p1_bot_q;
        p1_top_q    <= c_top;
        p1_mid_q    <= c_mid;
        p1_bot_q    <= s1_gray_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign edge_value_o  = edge_q;
  assign window_full_o = out_tag_q.full;
  assign center_row_o  = out_tag_q.crow;
  assign center_col_o  = out_tag_q.ccol;
  assign frame_last_o  = out_tag_q.last;

endmodule

### hw/rtl/gray_prewitt_edge_threshold_top.sv
// An accepted pixel request passes the queue, the s1 register and the output register.
// Throughput: one pixel per cycle without output stalls, set by the line store's single read and single write port.
// A four-entry queue between the front and back end absorbs short output stalls.
// Reset clears the position counters, the queue, the window and the output valid flag,
// and loads cutoff 95, width 640 and height 480. The line store is not cleared.
// ----------------------------------------------------------------------------
// Gray Prewitt edge threshold top level
// Configuration registers and the front end, queue and back end.
// ----------------------------------------------------------------------------
module gray_prewitt_edge_threshold_top import gpe_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH,
  parameter int MaxHeight = MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      red_in_i,
  input  logic [PIX_W-1:0]      green_in_i,
  input  logic [PIX_W-1:0]      blue_in_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      edge_value_o,
  output logic                  window_full_o,
  output logic [POS_W-1:0]      center_row_o,
  output logic [POS_W-1:0]      center_col_o,
  output logic                  frame_last_o
);

  localparam int CW = $clog2(MaxWidth);
  localparam int QW = CW + PIX_W + $bits(gpe_tag_t);

  logic [CUTOFF_W-1:0] cutoff_q;
  logic [DIM_W-1:0]    width_q, height_q;
  logic                push, push_ready, head_valid, head_ready;
  logic [CW-1:0]       item_col, head_col;
  logic [PIX_W-1:0]    item_gray, head_gray;
  gpe_tag_t            item_tag, head_tag;
  logic [QW-1:0]       head_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (gpe_cfg_e'(cfg_index_i))
        CFG_CUTOFF: cutoff_q <= CUTOFF_W'(cfg_data_i);
        CFG_WIDTH:  width_q  <= DIM_W'(cfg_data_i);
        CFG_HEIGHT: height_q <= DIM_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  gpe_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .frame_start_i (frame_start_i),
    .width_i       (width_q),
    .height_i      (height_q),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .item_col_o    (item_col),
    .item_gray_o   (item_gray),
    .item_tag_o    (item_tag)
  );

  gpe_fifo #(
    .Width (QW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  ({item_col, item_gray, item_tag}),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_data_o   (head_data)
  );

  assign {head_col, head_gray, head_tag} = head_data;

  gpe_back #(
    .MaxWidth (MaxWidth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_ready_o  (head_ready),
    .head_col_i    (head_col),
    .head_gray_i   (head_gray),
    .head_tag_i    (head_tag),
    .cutoff_i      (cutoff_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_value_o  (edge_value_o),
    .window_full_o (window_full_o),
    .center_row_o  (center_row_o),
    .center_col_o  (center_col_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

### hw/rtl/gpe_checker.sv
// ----------------------------------------------------------------------------
// Gray Prewitt port checker
// Concurrent checks on the result channel of the top level.
// ----------------------------------------------------------------------------
module gpe_checker import gpe_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] edge_value_o,
  input logic             window_full_o,
  input logic [POS_W-1:0] center_row_o,
  input logic [POS_W-1:0] center_col_o,
  input logic             frame_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(edge_value_o) && $stable(window_full_o)
      && $stable(center_row_o) && $stable(center_col_o) && $stable(frame_last_o))
    else $error("Result payload changed while stalled.");

  a_edge_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (edge_value_o == EDGE_ON) || (edge_value_o == EDGE_OFF))
    else $error("Edge value is neither on nor off.");

  a_partial_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_full_o |-> (edge_value_o == EDGE_OFF)
      && (center_row_o == '0) && (center_col_o == '0))
    else $error("Partial window result is not masked.");

endmodule

bind gray_prewitt_edge_threshold_top gpe_checker u_gpe_checker (.*);
